// ----- rtl/core/pgh_pkg.sv -----
// shared types, constants and helpers of the packed gradient histogram
`timescale 1ns / 1ps

package pgh_pkg;

  // item opcodes
  typedef enum logic [1:0] {
    OP_ACC   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // configuration register indexes
  localparam logic CFG_HIST_MODE = 1'b0;
  localparam logic CFG_HESS_EN   = 1'b1;

  // entry width codes
  typedef enum logic [1:0] {
    W16 = 2'd0,
    W32 = 2'd1,
    W64 = 2'd2
  } width_t;

  localparam int unsigned BIN_W     = 8;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned ENTRY_W   = 64;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_DATA_W = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [7:0]  BYTE_MASK = 8'hff;

  // one classified job handed from front to back
  typedef struct packed {
    op_t                 kind;
    logic                emit;
    logic [BIN_W-1:0]    bin;
    logic [ENTRY_W-1:0]  value;
    width_t              width;
  } job_t;

  // mode three behaves as the 64-bit mode
  function automatic width_t width_of(input logic [MODE_W-1:0] mode);
    width_t w;
    case (mode)
      2'd0:    w = W16;
      2'd1:    w = W32;
      default: w = W64;
    endcase
    return w;
  endfunction

  function automatic logic [ENTRY_W-1:0] width_mask(input width_t w);
    logic [ENTRY_W-1:0] m;
    case (w)
      W16:     m = {48'd0, 16'hffff};
      W32:     m = {32'd0, 32'hffff_ffff};
      default: m = '1;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/core/pgh_if.sv -----
// channel interfaces: items in, results out, configuration writes
`timescale 1ns / 1ps

interface pgh_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  bin_index;
  logic [15:0] grad_hess;
  logic        last;

  modport source (output valid, opcode, bin_index, grad_hess, last, input ready);
  modport sink   (input valid, opcode, bin_index, grad_hess, last, output ready);
endinterface

interface pgh_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_bin;
  logic [63:0] entry_value;

  modport source (output valid, out_bin, entry_value, input ready);
  modport sink   (input valid, out_bin, entry_value, output ready);
endinterface

interface pgh_cfg_if;
  logic       valid;
  logic       ready;
  logic       index;
  logic [1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/pgh_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pgh_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/pgh_front.sv -----
// front end: accepts items, drops ignored ones, builds the packed addend
`timescale 1ns / 1ps

module pgh_front import pgh_pkg::*; #(
  parameter int unsigned NUM_BINS = 256
) (
  pgh_item_if.sink              items,
  input  logic [MODE_W-1:0]     hist_mode,
  input  logic                  hess_en,
  input  logic                  q_ready,
  output logic                  q_push,
  output job_t                  q_job
);

  localparam int unsigned DEPTH     = (NUM_BINS < 256) ? NUM_BINS : 256;
  localparam logic [BIN_W:0] BIN_LIMIT = (BIN_W+1)'(DEPTH);

  op_t          kind;
  width_t       width;
  logic         in_range;
  logic [7:0]   grad;
  logic [7:0]   low;
  logic [ENTRY_W-1:0] packed_val;

  assign kind     = op_t'(items.opcode);
  assign width    = width_of(hist_mode);
  assign in_range = {1'b0, items.bin_index} < BIN_LIMIT;
  assign grad     = items.grad_hess[15:8] & BYTE_MASK;
  assign low      = hess_en ? items.grad_hess[7:0] : 8'd1;

  // packed addend: whole word in 16-bit mode, gradient over hessian or count otherwise
  always_comb begin
    case (width)
      W16:     packed_val = {48'd0, items.grad_hess};
      W32:     packed_val = {32'd0, {8{grad[7]}}, grad, 8'd0, low};
      default: packed_val = {{24{grad[7]}}, grad, 24'd0, low};
    endcase
  end

  // stall only on a full queue; ignored items are taken and dropped
  assign items.ready = q_ready;
  assign q_push      = items.valid && q_ready && in_range && (kind != OP_NONE);

  always_comb begin
    q_job.kind  = kind;
    q_job.emit  = (kind == OP_READ) || ((kind == OP_ACC) && items.last);
    q_job.bin   = items.bin_index;
    q_job.value = packed_val;
    q_job.width = width;
  end

endmodule

// ----- rtl/core/pgh_queue.sv -----
// short job queue between front and back end
`timescale 1ns / 1ps

module pgh_queue import pgh_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic push_ready,
  input  logic pop,
  output job_t pop_job,
  output logic pop_valid
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = count != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = slots[rd_ptr];

  // pointer wrap at the queue depth
  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/core/pgh_back.sv -----
// back end: read-modify-write of the bin store and the result register
`timescale 1ns / 1ps

module pgh_back import pgh_pkg::*; #(
  parameter int unsigned NUM_BINS = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  job_t          q_job,
  output logic          q_pop,
  pgh_result_if.source  results
);

  localparam int unsigned DEPTH = (NUM_BINS < 256) ? NUM_BINS : 256;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t             state;
  job_t               job;
  logic               hit;
  logic [DEPTH-1:0]   entry_valid;
  logic [AW-1:0]      q_addr;
  logic [AW-1:0]      job_addr;
  logic               slot_free;
  logic               ram_re;
  logic               ram_we;
  logic [ENTRY_W-1:0] rdata;
  logic [ENTRY_W-1:0] old_val;
  logic [ENTRY_W-1:0] mask;
  logic [ENTRY_W-1:0] sum;

  assign q_addr   = q_job.bin[AW-1:0];
  assign job_addr = job.bin[AW-1:0];

  // result slot is free now or empties this cycle
  assign slot_free = !results.valid || results.ready;
  assign q_pop     = (state == ST_IDLE) && q_valid && (!q_job.emit || slot_free);
  assign ram_re    = q_pop && (q_job.kind != OP_CLEAR);
  assign ram_we    = (state == ST_EXEC) && (job.kind == OP_ACC);

  // entry never written since reset or clear reads as zero
  assign old_val = hit ? rdata : '0;
  assign mask    = width_mask(job.width);
  assign sum     = (old_val + job.value) & mask;

  pgh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (job_addr),
    .wdata (sum),
    .re    (ram_re),
    .raddr (q_addr),
    .rdata (rdata)
  );

  // sequencer, valid bits and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_valid   <= '0;
      results.valid <= 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (q_job.kind == OP_CLEAR) begin
              entry_valid[q_addr] <= 1'b0;
            end else begin
              job   <= q_job;
              hit   <= entry_valid[q_addr];
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (job.kind == OP_ACC) begin
            entry_valid[job_addr] <= 1'b1;
          end
          if (job.emit) begin
            results.valid       <= 1'b1;
            results.out_bin     <= job.bin;
            results.entry_value <= (job.kind == OP_ACC) ? sum : (old_val & mask);
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/packed_gradient_histogram_top.sv -----
// top level of the packed gradient histogram
//
// Channels: items carry opcode (accumulate, read, clear), bin_index,
// grad_hess and last; results carry out_bin and entry_value; cfg writes
// hist_mode (index 0) and hess_en (index 1), always ready.
// An accumulate with last set and every read give one result transaction;
// other items give none. Items on bins beyond NUM_BINS and opcode three are
// taken and dropped.
// The back end handles an accumulate or a read as a store read in the idle
// state, then add and write back in the exec state, and a clear in the idle
// state alone; with the single store read and then written, it takes no new
// item until the last one has left exec. With the back end idle, a taken item
// passes the queue, the job register and the result register before its
// result is presented. A two-entry queue separates the front from the back end.
// Reset: control clears, hist_mode goes to 0, hess_en to 1 and every
// bin reads as zero at once through per-bin valid flags.
// A stalled results channel holds the result; items needing no result keep
// going, and the queue then fills and drops items ready.
`timescale 1ns / 1ps

module packed_gradient_histogram_top import pgh_pkg::*; #(
  parameter int unsigned NUM_BINS = 256
) (
  input  logic         clk,
  input  logic         rst,
  pgh_item_if.sink     items,
  pgh_result_if.source results,
  pgh_cfg_if.sink      cfg
);

  logic [MODE_W-1:0] hist_mode;
  logic              hess_en;
  logic              q_push;
  logic              q_ready;
  logic              q_pop;
  logic              q_valid;
  job_t              push_job;
  job_t              head_job;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_mode <= '0;
      hess_en   <= 1'b1;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_HIST_MODE: hist_mode <= cfg.data[MODE_W-1:0];
        CFG_HESS_EN:   hess_en   <= cfg.data[0];
        default:       hist_mode <= hist_mode;
      endcase
    end
  end

  pgh_front #(
    .NUM_BINS (NUM_BINS)
  ) u_front (
    .items     (items),
    .hist_mode (hist_mode),
    .hess_en   (hess_en),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  pgh_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_job    (head_job),
    .pop_valid  (q_valid)
  );

  pgh_back #(
    .NUM_BINS (NUM_BINS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (head_job),
    .q_pop   (q_pop),
    .results (results)
  );

endmodule

// ----- verif/pgh_histogram_check.sv -----
// checker: predicts histogram results from observed transactions and compares them
`timescale 1ns / 1ps

module pgh_histogram_check import pgh_pkg::*; #(
  parameter int unsigned NUM_BINS = 256
) (
  input  logic  clk,
  input  logic  rst,
  pgh_item_if   items,
  pgh_result_if results,
  pgh_cfg_if    cfg,
  output int    mismatches,
  output int    outstanding
);

  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic [ENTRY_W-1:0] value;
  } bin_result_t;

  // predicted copy of the store and the registers
  logic [ENTRY_W-1:0] bin_store [NUM_BINS];
  logic [MODE_W-1:0]  hist_mode_q;
  logic               use_hess_q;
  bin_result_t        expected_entries[$];
  int                 mismatch_total;

  initial begin
    mismatches     = 0;
    outstanding    = 0;
    mismatch_total = 0;
  end

  // one line per mismatch, and count it
  task automatic report_mismatch(input string what);
    mismatch_total++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // increment that one accumulate adds to its bin at the given width
  function automatic logic [ENTRY_W-1:0] packed_increment(input width_t w, input logic hess,
                                                          input logic [WORD_W-1:0] word);
    logic [ENTRY_W-1:0] grad;
    logic [ENTRY_W-1:0] low;
    grad = {{(ENTRY_W-8){word[15]}}, word[15:8]};
    low  = hess ? {{(ENTRY_W-8){1'b0}}, word[7:0]} : {{(ENTRY_W-1){1'b0}}, 1'b1};
    if (w == W16) return {{(ENTRY_W-WORD_W){1'b0}}, word};
    if (w == W32) return ((grad << 16) | low) & {{32{1'b0}}, {32{1'b1}}};
    return (grad << 32) | low;
  endfunction

  always @(posedge clk) begin
    bin_result_t        want;
    width_t             w;
    logic [ENTRY_W-1:0] m;
    logic [ENTRY_W-1:0] sum;
    if (rst) begin
      for (int k = 0; k < NUM_BINS; k++) bin_store[k] = '0;
      hist_mode_q = W16;
      use_hess_q  = 1'b1;
      expected_entries.delete();
    end else begin
      // result transaction against the oldest expectation
      if (results.valid && results.ready) begin
        if (expected_entries.size() == 0) begin
          report_mismatch($sformatf("unexpected result bin %0d value %h",
                                    results.out_bin, results.entry_value));
        end else begin
          want = expected_entries.pop_front();
          if (results.out_bin !== want.bin)
            report_mismatch($sformatf("out_bin %0d, predicted %0d", results.out_bin, want.bin));
          if (results.entry_value !== want.value)
            report_mismatch($sformatf("bin %0d entry_value %h, predicted %h",
                                      want.bin, results.entry_value, want.value));
        end
      end

      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_HIST_MODE: hist_mode_q = cfg.data;
          CFG_HESS_EN:   use_hess_q  = cfg.data[0];
          default: ;
        endcase
      end

      // item transaction: update the store and queue any result
      if (items.valid && items.ready) begin
        w = (hist_mode_q == W16) ? W16 : (hist_mode_q == W32) ? W32 : W64;
        m = (w == W16) ? {{48{1'b0}}, {16{1'b1}}} :
            (w == W32) ? {{32{1'b0}}, {32{1'b1}}} : {ENTRY_W{1'b1}};
        if (int'(items.bin_index) < NUM_BINS) begin
          case (op_t'(items.opcode))
            OP_ACC: begin
              sum = (bin_store[items.bin_index] +
                     packed_increment(w, use_hess_q, items.grad_hess)) & m;
              bin_store[items.bin_index] = sum;
              if (items.last) begin
                want.bin   = items.bin_index;
                want.value = sum;
                expected_entries.push_back(want);
              end
            end
            OP_READ: begin
              want.bin   = items.bin_index;
              want.value = bin_store[items.bin_index] & m;
              expected_entries.push_back(want);
            end
            OP_CLEAR: bin_store[items.bin_index] = '0;
            default: ;
          endcase
        end
      end
    end
    mismatches  <= mismatch_total;
    outstanding <= expected_entries.size();
  end

endmodule

// ----- verif/tb_packed_gradient_histogram_top.sv -----
// testbench top: reset, stimulus, idling phases, watchdog and verdict
`timescale 1ns / 1ps

module tb_packed_gradient_histogram_top;
  import pgh_pkg::*;

  localparam int unsigned NUM_BINS        = 256;
  localparam int unsigned QUIET_LIMIT     = 4000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned PHASES          = 12;
  localparam int unsigned ITEMS_PER_PHASE = 145;
  localparam int unsigned PAUSE_PHASE     = 3;
  localparam logic [MODE_W-1:0] MODE_WIDE_ALIAS = 2'd3;

  logic        clk = 1'b0;
  logic        rst;
  int          sender_idle_pct;
  int          receiver_stall_pct;
  int          mismatches;
  int          outstanding;
  int unsigned quiet_cycles;
  logic [MODE_W-1:0] mode_cycle [4];

  pgh_item_if   items();
  pgh_result_if results();
  pgh_cfg_if    cfg();

  packed_gradient_histogram_top #(.NUM_BINS(NUM_BINS)) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .results (results),
    .cfg     (cfg)
  );

  pgh_histogram_check #(.NUM_BINS(NUM_BINS)) u_check (
    .clk         (clk),
    .rst         (rst),
    .items       (items),
    .results     (results),
    .cfg         (cfg),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    results.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (items.valid && items.ready) || (results.valid && results.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // present one item, with random idle cycles ahead of it, and wait for the transaction
  task automatic send_item(input op_t op, input logic [BIN_W-1:0] bin,
                           input logic [WORD_W-1:0] word, input logic last_flag);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid     <= 1'b1;
    items.opcode    <= op;
    items.bin_index <= bin;
    items.grad_hess <= word;
    items.last      <= last_flag;
    do @(posedge clk); while (!items.ready);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic settle();
    items.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write both registers back to back, valid held across the pair
  task automatic configure(input logic [MODE_W-1:0] mode, input logic hess);
    settle();
    cfg.valid <= 1'b1;
    cfg.index <= CFG_HIST_MODE;
    cfg.data  <= mode;
    do @(posedge clk); while (!cfg.ready);
    cfg.index <= CFG_HESS_EN;
    cfg.data  <= {1'b0, hess};
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // mostly accumulates on a few hot bins, with reads, clears and the odd dead opcode
  task automatic random_item(output bit counted);
    int unsigned       pick;
    op_t               op;
    logic [BIN_W-1:0]  bin;
    logic [WORD_W-1:0] word;
    pick = $urandom_range(0, 99);
    if (pick < 74)      op = OP_ACC;
    else if (pick < 90) op = OP_READ;
    else if (pick < 96) op = OP_CLEAR;
    else                op = OP_NONE;
    bin = ($urandom_range(0, 99) < 70) ? BIN_W'($urandom_range(0, 7))
                                       : BIN_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       word = 16'h7fff;
      1:       word = 16'h8000;
      2:       word = 16'hffff;
      3:       word = 16'h0000;
      default: word = WORD_W'($urandom);
    endcase
    send_item(op, bin, word, $urandom_range(0, 99) < 30);
    counted = (op != OP_NONE);
  endtask

  initial begin
    int unsigned n;
    bit          counted;
    mode_cycle = '{W16, W32, W64, MODE_WIDE_ALIAS};
    items.valid        = 1'b0;
    items.opcode       = OP_ACC;
    items.bin_index    = '0;
    items.grad_hess    = '0;
    items.last         = 1'b0;
    cfg.valid          = 1'b0;
    cfg.index          = CFG_HIST_MODE;
    cfg.data           = '0;
    results.ready      = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    rst                = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset values, wrap, clear, dead opcode, hessian switch, every mode
    send_item(OP_READ,  8'd0,   16'h0000, 1'b0);
    send_item(OP_READ,  8'd255, 16'h0000, 1'b0);
    send_item(OP_ACC,   8'd0,   16'hffff, 1'b1);
    send_item(OP_ACC,   8'd0,   16'h0001, 1'b1);
    send_item(OP_ACC,   8'd255, 16'h8000, 1'b0);
    send_item(OP_READ,  8'd255, 16'h0000, 1'b0);
    send_item(OP_ACC,   8'd255, 16'h7fff, 1'b1);
    send_item(OP_CLEAR, 8'd255, 16'hffff, 1'b1);
    send_item(OP_READ,  8'd255, 16'h0000, 1'b0);
    send_item(OP_NONE,  8'd5,   16'hffff, 1'b1);
    send_item(OP_READ,  8'd5,   16'h0000, 1'b0);
    send_item(OP_ACC,   8'd7,   16'h7f80, 1'b1);
    send_item(OP_ACC,   8'd7,   16'h00ff, 1'b0);
    configure(W16, 1'b0);
    send_item(OP_ACC,   8'd7,   16'h0101, 1'b1);
    configure(W32, 1'b1);
    send_item(OP_READ,  8'd7,   16'h0000, 1'b0);
    send_item(OP_ACC,   8'd0,   16'h80ff, 1'b1);
    send_item(OP_ACC,   8'd0,   16'h7f00, 1'b1);
    send_item(OP_ACC,   8'd1,   16'hffff, 1'b1);
    configure(W32, 1'b0);
    send_item(OP_ACC,   8'd3,   16'h12ab, 1'b1);
    configure(W64, 1'b1);
    send_item(OP_ACC,   8'd0,   16'h8001, 1'b1);
    send_item(OP_READ,  8'd0,   16'h0000, 1'b0);
    configure(MODE_WIDE_ALIAS, 1'b0);
    send_item(OP_ACC,   8'd1,   16'h7fff, 1'b1);
    send_item(OP_READ,  8'd255, 16'h0000, 1'b0);
    send_item(OP_CLEAR, 8'd0,   16'h0000, 1'b0);
    send_item(OP_READ,  8'd0,   16'h0000, 1'b0);

    // random phases: every mode code with each hessian setting, each mode code tied to one idling pattern, then random
    for (int p = 0; p < PHASES; p++) begin
      if (p < 8) configure(mode_cycle[p % 4], p / 4 == 0);
      else       configure(mode_cycle[$urandom_range(0, 3)], 1'($urandom_range(0, 1)));
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
        default: begin sender_idle_pct = 33; receiver_stall_pct = 33; end
      endcase
      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        random_item(counted);
        if (counted) n++;
        // sender holds off until the results channel has caught up
        if (p == PAUSE_PHASE && n == ITEMS_PER_PHASE / 2 && counted) settle();
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
